// ----- design/bsu_pkg.sv -----
// shared types and constants for the bucket sort unit
`timescale 1ns / 1ps
package bsu_pkg;

  localparam int SAMPLE_W = 16;
  localparam int BUCKET_W = 6;
  localparam int CFG_W    = 7;

  // commands from controller to datapath
  typedef struct packed {
    logic insert;  // place the incoming sample into the cell row
    logic shift;   // head transaction taken, move the row down by one
  } ctrl_cmd_t;

endpackage

// ----- design/bsu_ctrl.sv -----
// controller: load and drain sequencing, fill count and handshakes
`timescale 1ns / 1ps
module bsu_ctrl #(
  parameter int MAX_ITEMS = 64,
  parameter int CW        = $clog2(MAX_ITEMS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_batch_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_final_res,
  output logic [CW-1:0]      fill_count,
  output bsu_pkg::ctrl_cmd_t cmd
);
  import bsu_pkg::*;

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign in_ready      = (state_r == ST_LOAD);
  assign out_valid     = (state_r == ST_DRAIN);
  assign out_final_res = (count_r == CW'(1));
  assign fill_count    = count_r;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cmd.insert = 1'b0;
    cmd.shift  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.insert = 1'b1;
          count_nxt  = count_r + CW'(1);
          // a full row closes the batch as if the end flag were set
          if (in_batch_end || (count_r + CW'(1) == CW'(MAX_ITEMS))) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_ready) begin
          cmd.shift = 1'b1;
          count_nxt = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (count_r != '0))
    else $error("drain with empty row");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("load and drain at once");

  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_final_res) |=> (in_ready && count_r == '0))
    else $error("final transaction did not return to load");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("fill count beyond row length");

endmodule

// ----- design/bsu_datapath.sv -----
// datapath: insertion cell row, bucket count register and bucket index
`timescale 1ns / 1ps
module bsu_datapath #(
  parameter int MAX_ITEMS   = 64,
  parameter int MAX_BUCKETS = 64,
  parameter int CW          = $clog2(MAX_ITEMS + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bsu_pkg::CFG_W-1:0]      cfg_wdata,
  input  bsu_pkg::ctrl_cmd_t             cmd,
  input  logic [CW-1:0]                  fill_count,
  input  logic [bsu_pkg::SAMPLE_W-1:0]   in_sample,
  output logic [bsu_pkg::SAMPLE_W-1:0]   out_sorted_sample,
  output logic [bsu_pkg::BUCKET_W-1:0]   out_bucket
);
  import bsu_pkg::*;

  localparam int PW = CFG_W + SAMPLE_W;

  logic [SAMPLE_W-1:0] cell_r   [MAX_ITEMS];
  logic [SAMPLE_W-1:0] cell_nxt [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] gt;
  logic [CFG_W-1:0]    bcnt_r;
  logic [CFG_W-1:0]    eff_n;
  logic [PW-1:0]       prod;
  logic [CFG_W-1:0]    bidx;

  // empty cells count as larger than any sample
  genvar g;
  generate
    for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
      assign gt[g] = (CW'(g) >= fill_count) || (cell_r[g] > in_sample);
      if (g == 0) begin : g_head
        always_comb begin
          cell_nxt[g] = cell_r[g];
          if (cmd.insert) begin
            if (gt[g]) cell_nxt[g] = in_sample;
          end else if (cmd.shift) begin
            if (MAX_ITEMS > 1) cell_nxt[g] = cell_r[(MAX_ITEMS > 1) ? 1 : 0];
          end
        end
      end else begin : g_body
        always_comb begin
          cell_nxt[g] = cell_r[g];
          if (cmd.insert) begin
            if (gt[g-1])   cell_nxt[g] = cell_r[g-1];
            else if (gt[g]) cell_nxt[g] = in_sample;
          end else if (cmd.shift) begin
            if (g < MAX_ITEMS - 1) cell_nxt[g] = cell_r[(g < MAX_ITEMS - 1) ? g + 1 : g];
          end
        end
      end
      always_ff @(posedge clk) begin
        cell_r[g] <= cell_nxt[g];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= CFG_W'(1);
    end else if (cfg_we) begin
      bcnt_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (bcnt_r == '0) begin
      eff_n = CFG_W'(1);
    end else if (bcnt_r > CFG_W'(MAX_BUCKETS)) begin
      eff_n = CFG_W'(MAX_BUCKETS);
    end else begin
      eff_n = bcnt_r;
    end
    prod = PW'(eff_n) * PW'(cell_r[0]);
    bidx = prod[PW-1:SAMPLE_W];
    if (bidx > eff_n - CFG_W'(1)) bidx = eff_n - CFG_W'(1);
  end

  assign out_sorted_sample = cell_r[0];
  assign out_bucket        = bidx[BUCKET_W-1:0];

endmodule

// ----- design/bucket_sort_unit_interval_top.sv -----
// Loading takes one transaction per cycle; a batch holds up to MAX_ITEMS samples.
// The first sorted result is valid the cycle after the batch-closing transaction,
// then one result per cycle while out_ready is high, set by the insertion cell row.
// The next batch is accepted in the cycle after the final result is taken.
// Reset clears the fill count, the controller state and sets bucket_count to 1;
// the cell row contents are not cleared.
`timescale 1ns / 1ps
module bucket_sort_unit_interval_top #(
  parameter int MAX_ITEMS   = 64,
  parameter int MAX_BUCKETS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bsu_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bsu_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                         in_batch_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bsu_pkg::SAMPLE_W-1:0] out_sorted_sample,
  output logic [bsu_pkg::BUCKET_W-1:0] out_bucket,
  output logic                         out_final_res
);
  import bsu_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);

  ctrl_cmd_t     cmd;
  logic [CW-1:0] fill_count;

  bsu_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .CW        (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_batch_end  (in_batch_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_final_res (out_final_res),
    .fill_count    (fill_count),
    .cmd           (cmd)
  );

  bsu_datapath #(
    .MAX_ITEMS   (MAX_ITEMS),
    .MAX_BUCKETS (MAX_BUCKETS),
    .CW          (CW)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .fill_count        (fill_count),
    .in_sample         (in_sample),
    .out_sorted_sample (out_sorted_sample),
    .out_bucket        (out_bucket)
  );

endmodule

// ----- tb/sv/bucket_sort_unit_interval_top_test.sv -----
// self-checking testbench for the bucket sort unit: batches in, ascending results out
`timescale 1ns / 1ps
module bucket_sort_unit_interval_top_test;
  import bsu_pkg::*;

  localparam int BATCH_MAX  = 64;
  localparam int BUCKET_MAX = 64;
  localparam int RAND_ITEMS = 480;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [BUCKET_W-1:0] bucket;
    logic                last;
  } sorted_result_t;

  // keeps its own sorted copy of the open batch and the sorted results still owed
  class sorted_batch_board;
    logic [SAMPLE_W-1:0] open_batch[$];
    sorted_result_t      expected_sorted[$];
    logic [CFG_W-1:0]    bucket_count;
    int unsigned         errors;
    int unsigned         results_seen;
    int unsigned         batches_closed;

    function new();
      bucket_count   = CFG_W'(1);
      errors         = 0;
      results_seen   = 0;
      batches_closed = 0;
    endfunction

    function void set_bucket_count(logic [CFG_W-1:0] v);
      bucket_count = v;
    endfunction

    function int unsigned eff_buckets();
      int unsigned n;
      n = bucket_count;
      if (n == 0) n = 1;
      if (n > BUCKET_MAX) n = BUCKET_MAX;
      return n;
    endfunction

    function int pending();
      return expected_sorted.size();
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] v, logic batch_end);
      int i;
      int unsigned n;
      int unsigned b;
      sorted_result_t r;
      i = open_batch.size();
      while (i > 0 && open_batch[i-1] > v) i--;
      open_batch.insert(i, v);
      // a full store closes the batch even without the end flag
      if (!batch_end && open_batch.size() < BATCH_MAX) return;
      n = eff_buckets();
      foreach (open_batch[k]) begin
        b = (n * int'(open_batch[k])) >> 16;
        if (b > n - 1) b = n - 1;
        r.sample = open_batch[k];
        r.bucket = b[BUCKET_W-1:0];
        r.last   = (k == open_batch.size() - 1);
        expected_sorted.insert(expected_sorted.size(), r);
      end
      open_batch.delete();
      batches_closed++;
    endfunction

    function void check_sorted(logic [SAMPLE_W-1:0] s, logic [BUCKET_W-1:0] b, logic f);
      sorted_result_t e;
      results_seen++;
      if (expected_sorted.size() == 0) begin
        $display("%0t: unexpected result: sample %h bucket %0d final %b", $time, s, b, f);
        errors++;
        return;
      end
      e = expected_sorted.pop_front();
      if (s !== e.sample) begin
        $display("%0t: sorted_sample mismatch: expected %h, actual %h", $time, e.sample, s);
        errors++;
      end
      if (b !== e.bucket) begin
        $display("%0t: bucket mismatch: expected %0d, actual %0d", $time, e.bucket, b);
        errors++;
      end
      if (f !== e.last) begin
        $display("%0t: final_res mismatch: expected %b, actual %b", $time, e.last, f);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_batch_end;
  logic                out_valid;
  logic                out_ready;
  logic [SAMPLE_W-1:0] out_sorted_sample;
  logic [BUCKET_W-1:0] out_bucket;
  logic                out_final_res;

  sorted_batch_board board;
  bit                steady;
  int unsigned       items_sent;
  int unsigned       settings_used;

  bucket_sort_unit_interval_top #(
    .MAX_ITEMS  (BATCH_MAX),
    .MAX_BUCKETS(BUCKET_MAX)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_batch_end     (in_batch_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_sample(out_sorted_sample),
    .out_bucket       (out_bucket),
    .out_final_res    (out_final_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: check each transaction, then pick the next ready value
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_sorted(out_sorted_sample, out_bucket, out_final_res);
    out_ready <= steady || ($urandom_range(99) >= 21);
  end

  task automatic send_item(input logic [SAMPLE_W-1:0] s, input logic e);
    while (!steady && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_batch_end <= e;
    do @(posedge clk); while (!in_ready);
    board.note_sample(s, e);
    items_sent++;
  endtask

  task automatic write_bucket_count(input logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    // let the row drain its last transaction before touching the register
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_bucket_count(v);
    settings_used++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] prev);
    int unsigned n;
    int unsigned k;
    int unsigned v;
    int unsigned r;
    r = $urandom_range(99);
    n = board.eff_buckets();
    if (r < 6) return '0;
    if (r < 12) return '1;
    if (r < 20) return prev;
    if (r < 35 && n > 1) begin
      // near a bucket boundary
      k = $urandom_range(n - 1, 1);
      v = ((k << 16) / n) + $urandom_range(2) - 1;
      if (v > 16'hFFFF) v = 16'hFFFF;
      return v[SAMPLE_W-1:0];
    end
    return SAMPLE_W'($urandom_range(16'hFFFF));
  endfunction

  task automatic send_random_batch();
    int unsigned kind;
    int unsigned len;
    bit          flagged;
    logic [SAMPLE_W-1:0] s;
    kind    = $urandom_range(99);
    flagged = 1'b1;
    s       = SAMPLE_W'($urandom_range(16'hFFFF));
    if (kind < 8) begin
      len     = BATCH_MAX;
      flagged = 1'b0;
    end else if (kind < 12) begin
      len = BATCH_MAX;
    end else if (kind < 16) begin
      len = BATCH_MAX - 1;
    end else begin
      len = $urandom_range(10, 1);
    end
    for (int i = 0; i < len; i++) begin
      s = pick_sample(s);
      send_item(s, flagged && (i == len - 1));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] cfg_pick;
    int unsigned      batches;
    board         = new();
    steady        = 1'b0;
    items_sent    = 0;
    settings_used = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_sample     = '0;
    in_batch_end  = 1'b0;
    out_ready     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of one bucket: extremes, midpoint and a batch of one
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h8000, 1'b1);
    send_item(16'h7FFF, 1'b1);

    // zero is taken as one bucket
    write_bucket_count(7'd0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0001, 1'b1);

    // above the maximum saturates; equal values stay together
    write_bucket_count(7'h7F);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h0400, 1'b0);
    send_item(16'h03FF, 1'b0);
    send_item(16'h1234, 1'b0);
    send_item(16'h1234, 1'b1);

    write_bucket_count(7'd64);
    send_item(16'hFC00, 1'b0);
    send_item(16'hFBFF, 1'b0);
    send_item(16'h0400, 1'b1);

    // thirds do not split evenly
    write_bucket_count(7'd3);
    send_item(16'h5555, 1'b0);
    send_item(16'h5556, 1'b0);
    send_item(16'hAAAA, 1'b0);
    send_item(16'hAAAB, 1'b0);
    send_item(16'hFFFF, 1'b1);

    while (items_sent < RAND_ITEMS) begin
      case ($urandom_range(7))
        0: cfg_pick = 7'd1;
        1: cfg_pick = 7'd64;
        2: cfg_pick = 7'd0;
        3: cfg_pick = 7'h7F;
        4: cfg_pick = 7'd2;
        5: cfg_pick = 7'd63;
        default: cfg_pick = CFG_W'($urandom_range(7'h7F));
      endcase
      write_bucket_count(cfg_pick);
      steady  = (items_sent > 170 && items_sent < 320);
      batches = $urandom_range(4, 1);
      repeat (batches) send_random_batch();
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d samples loaded in %0d batches under %0d bucket settings",
             items_sent, board.batches_closed, settings_used + 1);
    $display("%0d sorted results checked, %0d errors", board.results_seen, board.errors);
    if (board.errors == 0 && board.pending() == 0 && board.open_batch.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
